// ----- rtl/sacc_pkg.sv -----
// Shared types, codes and default sizes for the set-associative cache controller.
// Used by every module of the block but sacc_ram; depends on nothing.
package sacc_pkg;

  // Set count and line size are powers of two; the way count need not be.
  localparam int NUM_SETS_DEF   = 128;
  localparam int NUM_WAYS_DEF   = 8;
  localparam int LINE_BYTES_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;

  localparam int WAY_IDX_W = 4;

  localparam logic [15:0] SEED_RESET = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] ACT_READ_HIT     = 3'd0;
  localparam logic [2:0] ACT_READ_FILL    = 3'd1;
  localparam logic [2:0] ACT_READ_BYPASS  = 3'd2;
  localparam logic [2:0] ACT_WRITE_UPDATE = 3'd3;
  localparam logic [2:0] ACT_WRITE_INVAL  = 3'd4;
  localparam logic [2:0] ACT_WRITE_MEM    = 3'd5;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
    logic [2:0]  access_length;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  action;
    logic [6:0]  set_index;
    logic [2:0]  way;
    logic [5:0]  byte_offset;
    logic [31:0] line_address;
    logic [31:0] store_data;
    logic        second_invalidate;
    logic [6:0]  second_set;
    logic [2:0]  second_way;
  } resp_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] hit_way;
    logic                 has_free;
    logic [WAY_IDX_W-1:0] free_way;
  } lookup_t;

endpackage

// ----- rtl/sacc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependency.
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sacc_lookup.sv -----
// Tag compare over one set row: lowest matching valid way and lowest free way.
// Depends on sacc_pkg for the lookup result type.
module sacc_lookup #(
  parameter int NUM_WAYS = 8,
  parameter int TAG_W    = 19
) (
  input  logic [NUM_WAYS*(TAG_W+1)-1:0] row,
  input  logic [TAG_W-1:0]              tag,
  output sacc_pkg::lookup_t             result
);

  localparam int VLD_LSB = NUM_WAYS * TAG_W;

  always_comb begin
    result = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (row[VLD_LSB + w] && (row[w*TAG_W +: TAG_W] == tag)) begin
        result.hit     = 1'b1;
        result.hit_way = sacc_pkg::WAY_IDX_W'(w);
      end
      if (!row[VLD_LSB + w]) begin
        result.has_free = 1'b1;
        result.free_way = sacc_pkg::WAY_IDX_W'(w);
      end
    end
  end

endmodule

// ----- rtl/sacc_victim.sv -----
// Victim LFSR with its seed register and a pipelined reduction modulo the way count.
// Depends on sacc_pkg for the seed, taps and way index width.
module sacc_victim #(
  parameter int NUM_WAYS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [15:0]                    seed,
  input  logic                           advance,
  output logic                           settling,
  output logic [sacc_pkg::WAY_IDX_W-1:0] victim
);

  localparam int RECIP_SH = 20;
  localparam logic [20:0] RECIP = 21'((1 << RECIP_SH) / NUM_WAYS);

  logic [15:0] lfsr;
  logic [15:0] lfsr_d;
  logic [15:0] quot;
  logic [15:0] lfsr_next;
  logic [36:0] prod;
  logic [15:0] rem;

  always_comb begin
    lfsr_next = {1'b0, lfsr[15:1]};
    if (lfsr[0]) begin
      lfsr_next = lfsr_next ^ sacc_pkg::LFSR_TAPS;
    end
  end

  assign prod = 37'(lfsr) * 37'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr     <= sacc_pkg::SEED_RESET;
      settling <= 1'b1;
    end else begin
      settling <= load;
      if (load) begin
        lfsr <= (seed == 16'd0) ? 16'd1 : seed;
      end else if (advance) begin
        lfsr <= lfsr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    lfsr_d <= lfsr;
    quot   <= 16'(prod >> RECIP_SH);
  end

  assign rem    = lfsr_d - 16'(quot * 16'(NUM_WAYS));
  assign victim = (rem >= 16'(NUM_WAYS)) ? sacc_pkg::WAY_IDX_W'(rem - 16'(NUM_WAYS))
                                         : sacc_pkg::WAY_IDX_W'(rem);

endmodule

// ----- rtl/set_assoc_cache_controller_unit.sv -----
// Tag and policy controller for a set-associative write-through cache.
// Depends on sacc_pkg, sacc_ram, sacc_lookup and sacc_victim.
//
// Usage: an access word enters on req with req_valid and is taken when
// req_stall is low. The result word leaves on rsp with rsp_valid and is
// taken when rsp_stall is low. The seed register is written through
// cfg_valid and cfg_data; cfg_ready is always high. A seed write also loads
// the victim LFSR and holds off new accesses while cfg_valid or the
// victim's settling flag is high. Tags and valid bits of one set share a
// row of a single RAM with a registered read. An access reads its row in
// the cycle it is taken; a modified row is written back from S_LOOK, for
// a read fill once the output register is free. A crossing write hit also
// reads the next set's row and clears a matching way there in S_SECOND.
// The result word is registered when the access leaves S_LOOK or S_SECOND.
// After reset the block sweeps the RAM one set a cycle to clear the valid
// bits of all sets, with req_stall high; seed writes are taken as ever.
// A new access is taken while a result still waits on rsp. When the
// receiver stalls and a second result is ready, the block holds that
// access, without touching the RAM, until the output register frees.
module set_assoc_cache_controller_unit #(
  parameter int NUM_SETS   = sacc_pkg::NUM_SETS_DEF,
  parameter int NUM_WAYS   = sacc_pkg::NUM_WAYS_DEF,
  parameter int LINE_BYTES = sacc_pkg::LINE_BYTES_DEF,
  parameter int ADDR_BITS  = sacc_pkg::ADDR_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sacc_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output sacc_pkg::resp_t rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data
);

  localparam int OFF_W   = $clog2(LINE_BYTES);
  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int TAG_W   = ADDR_BITS - OFF_W - SET_W;
  localparam int ROW_W   = NUM_WAYS * (TAG_W + 1);
  localparam int VLD_LSB = NUM_WAYS * TAG_W;
  localparam int IW      = sacc_pkg::WAY_IDX_W;

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_LOOK   = 2'd2;
  localparam logic [1:0] S_SECOND = 2'd3;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [SET_W-1:0]     clr_idx;
  sacc_pkg::req_t       cur;
  logic [IW-1:0]        way1;

  logic                 accept;
  logic [ADDR_BITS-1:0] req_addr;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS-1:0] addr2;
  logic [2:0]           len;
  logic [OFF_W-1:0]     off;
  logic [SET_W-1:0]     set;
  logic [SET_W-1:0]     set2;
  logic [TAG_W-1:0]     tag;
  logic [TAG_W-1:0]     tag2;
  logic                 crosses;

  logic                 ram_we;
  logic [SET_W-1:0]     ram_waddr;
  logic [ROW_W-1:0]     ram_wdata;
  logic                 ram_re;
  logic [SET_W-1:0]     ram_raddr;
  logic [ROW_W-1:0]     row;
  logic [ROW_W-1:0]     row_fill;
  logic [ROW_W-1:0]     row_inv;

  sacc_pkg::lookup_t    lk;
  logic                 settling;
  logic [IW-1:0]        victim;
  logic [IW-1:0]        pick;
  logic                 advance;

  logic                 out_free;
  logic                 go_second;
  logic                 finish;
  sacc_pkg::resp_t      rsp_next;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE) || cfg_valid || settling;
  assign accept    = req_valid && !req_stall;
  assign req_addr  = ADDR_BITS'(req.address);

  always_comb begin
    addr = ADDR_BITS'(cur.address);
    len  = cur.access_length;
    if (len == 3'd0) begin
      len = 3'd1;
    end else if (len > 3'd4) begin
      len = 3'd4;
    end
    off     = addr[OFF_W-1:0];
    set     = addr[OFF_W +: SET_W];
    tag     = addr[ADDR_BITS-1 -: TAG_W];
    crosses = ({1'b0, off} + (OFF_W+1)'(len)) > (OFF_W+1)'(LINE_BYTES);
    addr2   = addr + ADDR_BITS'(len);
    set2    = addr2[OFF_W +: SET_W];
    tag2    = addr2[ADDR_BITS-1 -: TAG_W];
  end

  sacc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (row)
  );

  sacc_lookup #(
    .NUM_WAYS (NUM_WAYS),
    .TAG_W    (TAG_W)
  ) u_lookup (
    .row    (row),
    .tag    ((state == S_SECOND) ? tag2 : tag),
    .result (lk)
  );

  sacc_victim #(
    .NUM_WAYS (NUM_WAYS)
  ) u_victim (
    .clk      (clk),
    .rst      (rst),
    .load     (cfg_valid && cfg_ready),
    .seed     (cfg_data),
    .advance  (advance),
    .settling (settling),
    .victim   (victim)
  );

  assign out_free  = !rsp_valid || !rsp_stall;
  assign go_second = (state == S_LOOK) && (cur.opcode == sacc_pkg::OP_WRITE) &&
                     lk.hit && crosses;
  assign finish    = out_free &&
                     (((state == S_LOOK) && !go_second) || (state == S_SECOND));
  assign pick      = lk.has_free ? lk.free_way : victim;

  always_comb begin
    row_fill = row;
    row_inv  = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (IW'(w) == pick) begin
        row_fill[w*TAG_W +: TAG_W] = tag;
        row_fill[VLD_LSB + w]      = 1'b1;
      end
      if (IW'(w) == lk.hit_way) begin
        row_inv[VLD_LSB + w] = 1'b0;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set;
    ram_wdata = row_fill;
    ram_re    = 1'b0;
    ram_raddr = req_addr[OFF_W +: SET_W];
    advance   = 1'b0;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_re = accept;
      end
      S_LOOK: begin
        if (go_second) begin
          ram_we    = 1'b1;
          ram_wdata = row_inv;
          ram_re    = 1'b1;
          ram_raddr = set2;
        end else if (finish && (cur.opcode == sacc_pkg::OP_READ) && !crosses && !lk.hit) begin
          ram_we  = 1'b1;
          advance = !lk.has_free;
        end
      end
      S_SECOND: begin
        ram_we    = finish && lk.hit;
        ram_waddr = set2;
        ram_wdata = row_inv;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_next                   = '0;
    rsp_next.set_index         = 7'(set);
    rsp_next.byte_offset       = 6'(off);
    rsp_next.line_address      = 32'({addr[ADDR_BITS-1:OFF_W], OFF_W'(0)});
    rsp_next.store_data        = (cur.opcode == sacc_pkg::OP_WRITE) ? cur.write_data : 32'd0;
    if (state == S_SECOND) begin
      rsp_next.hit               = 1'b1;
      rsp_next.action            = sacc_pkg::ACT_WRITE_INVAL;
      rsp_next.way               = 3'(way1);
      rsp_next.second_invalidate = lk.hit;
      rsp_next.second_set        = 7'(set2);
      rsp_next.second_way        = lk.hit ? 3'(lk.hit_way) : 3'd0;
    end else if (cur.opcode == sacc_pkg::OP_READ) begin
      if (crosses) begin
        rsp_next.action = sacc_pkg::ACT_READ_BYPASS;
      end else if (lk.hit) begin
        rsp_next.hit    = 1'b1;
        rsp_next.action = sacc_pkg::ACT_READ_HIT;
        rsp_next.way    = 3'(lk.hit_way);
      end else begin
        rsp_next.action = sacc_pkg::ACT_READ_FILL;
        rsp_next.way    = 3'(pick);
      end
    end else begin
      if (lk.hit) begin
        rsp_next.hit    = 1'b1;
        rsp_next.action = sacc_pkg::ACT_WRITE_UPDATE;
        rsp_next.way    = 3'(lk.hit_way);
      end else begin
        rsp_next.action = sacc_pkg::ACT_WRITE_MEM;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == SET_W'(NUM_SETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        if (go_second) begin
          state_next = S_SECOND;
        end else if (finish) begin
          state_next = S_IDLE;
        end
      end
      S_SECOND: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + SET_W'(1);
      end
      if (finish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
    if (go_second) begin
      way1 <= lk.hit_way;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    finish |-> (!rsp_valid || !rsp_stall))
    else $error("result loaded while the output word is still held");

  a_miss_action: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.hit) |-> (rsp.action == sacc_pkg::ACT_READ_FILL ||
                                 rsp.action == sacc_pkg::ACT_READ_BYPASS ||
                                 rsp.action == sacc_pkg::ACT_WRITE_MEM))
    else $error("miss result carries a hit action");

  a_row_conflict: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("same set row read and written in one cycle");

  a_second_flow: assert property (@(posedge clk) disable iff (rst)
    (state == S_SECOND) |-> ($past(state) == S_LOOK || $past(state) == S_SECOND))
    else $error("next-set lookup entered without a first lookup");
`endif

endmodule

// ----- bench/sacc_decision_checker.sv -----
// Checker for the set-associative cache controller: watches the access, result and seed channels.
// Predicts each result word from its own tag, valid and LFSR state and compares it field by field.
// Depends on sacc_pkg.
module sacc_decision_checker
  import sacc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  resp_t       rsp,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  localparam int LINES = NUM_SETS_DEF * NUM_WAYS_DEF;

  logic [18:0] way_tag [LINES];
  bit          way_live [LINES];
  logic [15:0] victim_sr;
  resp_t       decision_q [$];

  function automatic int find_way(logic [6:0] s, logic [18:0] t);
    for (int w = 0; w < NUM_WAYS_DEF; w++) begin
      if (way_live[int'(s) * NUM_WAYS_DEF + w] && way_tag[int'(s) * NUM_WAYS_DEF + w] == t) begin
        return w;
      end
    end
    return -1;
  endfunction

  function automatic resp_t decide_access(req_t r);
    resp_t       d;
    logic [2:0]  len;
    logic [5:0]  off;
    logic [6:0]  set_i;
    logic [18:0] tag_i;
    logic [31:0] next_addr;
    int          base;
    int          w;
    int          w2;
    int          pick;
    bit          crosses;
    len = r.access_length;
    if (len == 3'd0) begin
      len = 3'd1;
    end else if (len > 3'd4) begin
      len = 3'd4;
    end
    off = r.address[5:0];
    set_i = r.address[12:6];
    tag_i = r.address[31:13];
    base = int'(set_i) * NUM_WAYS_DEF;
    crosses = int'(off) + int'(len) > LINE_BYTES_DEF;
    d = '0;
    d.set_index = set_i;
    d.byte_offset = off;
    d.line_address = {r.address[31:6], 6'd0};
    if (r.opcode == OP_READ) begin
      if (crosses) begin
        d.action = ACT_READ_BYPASS;
      end else begin
        w = find_way(set_i, tag_i);
        if (w >= 0) begin
          d.hit = 1'b1;
          d.action = ACT_READ_HIT;
          d.way = w[2:0];
        end else begin
          pick = -1;
          for (int i = 0; i < NUM_WAYS_DEF; i++) begin
            if (pick < 0 && !way_live[base + i]) begin
              pick = i;
            end
          end
          if (pick < 0) begin
            pick = int'(victim_sr[2:0]);
            victim_sr = victim_sr[0] ? ((victim_sr >> 1) ^ LFSR_TAPS) : (victim_sr >> 1);
          end
          way_live[base + pick] = 1'b1;
          way_tag[base + pick] = tag_i;
          d.action = ACT_READ_FILL;
          d.way = pick[2:0];
        end
      end
    end else begin
      d.store_data = r.write_data;
      w = find_way(set_i, tag_i);
      if (w < 0) begin
        d.action = ACT_WRITE_MEM;
      end else begin
        d.hit = 1'b1;
        d.way = w[2:0];
        if (!crosses) begin
          d.action = ACT_WRITE_UPDATE;
        end else begin
          d.action = ACT_WRITE_INVAL;
          way_live[base + w] = 1'b0;
          next_addr = r.address + 32'(len);
          d.second_set = next_addr[12:6];
          w2 = find_way(next_addr[12:6], next_addr[31:13]);
          if (w2 >= 0) begin
            way_live[int'(next_addr[12:6]) * NUM_WAYS_DEF + w2] = 1'b0;
            d.second_invalidate = 1'b1;
            d.second_way = w2[2:0];
          end
        end
      end
    end
    return d;
  endfunction

  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    resp_t want;
    if (rst) begin
      for (int i = 0; i < LINES; i++) begin
        way_live[i] = 1'b0;
      end
      victim_sr = SEED_RESET;
      decision_q.delete();
      errors = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (decision_q.size() == 0) begin
          $display("%0t: result word with none expected, actual %h", $time, rsp);
          errors++;
        end else begin
          want = decision_q.pop_front();
          check_field("hit", want.hit, rsp.hit);
          check_field("action", want.action, rsp.action);
          check_field("set_index", want.set_index, rsp.set_index);
          check_field("way", want.way, rsp.way);
          check_field("byte_offset", want.byte_offset, rsp.byte_offset);
          check_field("line_address", want.line_address, rsp.line_address);
          check_field("store_data", want.store_data, rsp.store_data);
          check_field("second_invalidate", want.second_invalidate, rsp.second_invalidate);
          check_field("second_set", want.second_set, rsp.second_set);
          check_field("second_way", want.second_way, rsp.second_way);
        end
      end
      if (cfg_valid && cfg_ready) begin
        victim_sr = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
      end
      if (req_valid && !req_stall) begin
        decision_q.push_back(decide_access(req));
      end
    end
    outstanding <= decision_q.size();
  end

endmodule

// ----- bench/tb_set_assoc_cache_controller_unit.sv -----
// Top of the cache controller testbench: clock, reset, access and seed stimulus, result stalls.
// Depends on sacc_pkg, set_assoc_cache_controller_unit and sacc_decision_checker.
module tb_set_assoc_cache_controller_unit;
  import sacc_pkg::*;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  resp_t       rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          errors;
  int          outstanding;
  bit          no_gaps;
  logic [18:0] tag_pool [10];
  logic [6:0]  set_base;
  req_t        script [$];

  set_assoc_cache_controller_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sacc_decision_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic req_t word_of(logic op, logic [31:0] a, logic [2:0] len, logic [31:0] d);
    req_t w;
    w.opcode = op;
    w.address = a;
    w.access_length = len;
    w.write_data = d;
    return w;
  endfunction

  task automatic send_word(req_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      req_valid <= 1'b0;
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= w;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic play;
    foreach (script[i]) begin
      if ($urandom_range(0, 49) == 0) begin
        no_gaps = !no_gaps;
      end
      send_word(script[i]);
    end
    script.delete();
  endtask

  task automatic drain;
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_seed(logic [15:0] s);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= s;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_random(int n);
    logic [18:0] t;
    logic [6:0]  s;
    logic [5:0]  off;
    logic [2:0]  len;
    logic        op;
    int          roll;
    while (script.size() < n) begin
      roll = $urandom_range(0, 99);
      t = tag_pool[$urandom_range(0, 9)];
      s = set_base + 7'($urandom_range(0, 3));
      if (roll < 12) begin
        // Fill a line and the one after it, then store across their boundary.
        script.push_back(word_of(OP_READ, {t, s, 6'd0}, 3'd1, 32'd0));
        script.push_back(word_of(OP_READ, {t, s, 6'd0} + 32'd64, 3'd1, 32'd0));
        off = 6'($urandom_range(61, 63));
        script.push_back(word_of(OP_WRITE, {t, s, off}, 3'd4, $urandom()));
      end else if (roll < 88) begin
        op = ($urandom_range(0, 99) < 55) ? OP_READ : OP_WRITE;
        off = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(58, 63)) : 6'($urandom_range(0, 63));
        len = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
        script.push_back(word_of(op, {t, s, off}, len, $urandom()));
      end else begin
        op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
        script.push_back(word_of(op, $urandom(), 3'($urandom_range(0, 7)), $urandom()));
      end
    end
  endtask

  initial begin : rsp_side
    int n;
    rsp_stall = 1'b0;
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 5);
      repeat (n) begin
        @(negedge clk);
        rsp_stall <= 1'b1;
      end
      @(negedge clk);
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin : stimulus
    logic [15:0] seeds [5];
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = 16'd0;
    no_gaps = 1'b0;
    seeds[0] = 16'd1;
    seeds[1] = 16'hFFFF;
    seeds[2] = 16'd0;
    seeds[3] = 16'($urandom_range(1, 65535));
    seeds[4] = 16'($urandom());
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    script.push_back(word_of(OP_READ, 32'h0000_0000, 3'd1, 32'd0));
    script.push_back(word_of(OP_READ, 32'h0000_0000, 3'd4, 32'd0));
    script.push_back(word_of(OP_WRITE, 32'h0000_0000, 3'd4, 32'hFFFF_FFFF));
    script.push_back(word_of(OP_WRITE, 32'h0000_0040, 3'd2, 32'h1234_5678));
    script.push_back(word_of(OP_READ, 32'h0000_003E, 3'd4, 32'd0));
    script.push_back(word_of(OP_WRITE, 32'hFFFF_FFFF, 3'd1, 32'hA5A5_A5A5));
    script.push_back(word_of(OP_READ, 32'hFFFF_FFC0, 3'd1, 32'd0));
    script.push_back(word_of(OP_WRITE, 32'hFFFF_FFFE, 3'd4, 32'h5A5A_5A5A));
    script.push_back(word_of(OP_READ, 32'h0000_0000, 3'd1, 32'd0));
    script.push_back(word_of(OP_WRITE, 32'h0000_007E, 3'd3, 32'h0000_0001));
    script.push_back(word_of(OP_READ, 32'h0000_0040, 3'd1, 32'd0));
    script.push_back(word_of(OP_WRITE, 32'h0000_003D, 3'd4, 32'hDEAD_BEEF));
    for (int t = 0; t < 10; t++) begin
      script.push_back(word_of(OP_READ, {19'(t), 7'd2, 6'd0}, 3'd1, 32'd0));
    end
    script.push_back(word_of(OP_READ, 32'h0000_0081, 3'd0, 32'd0));
    script.push_back(word_of(OP_WRITE, 32'h0000_0080, 3'd7, 32'h8000_0001));
    script.push_back(word_of(OP_READ, 32'h0000_00BF, 3'd7, 32'd0));
    play();
    drain();

    foreach (seeds[p]) begin
      tag_pool[0] = 19'd0;
      tag_pool[1] = 19'h7FFFF;
      for (int i = 2; i < 10; i++) begin
        tag_pool[i] = 19'($urandom());
      end
      set_base = 7'($urandom_range(0, 127));
      write_seed(seeds[p]);
      plan_random(380);
      play();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
